// ===== design/amgs_pkg.sv =====
// ----------------------------------------------------------------------------
// amgs_pkg
// Shared sizes, codes, item types and helpers of the graph store.
// ----------------------------------------------------------------------------
package amgs_pkg;

  localparam int NV    = 64;             // number of vertices
  localparam int VW    = $clog2(NV);     // row / column index width
  localparam int CW    = VW + 1;         // degree count width, holds NV
  localparam int VTX_W = 7;              // vertex and degree field width

  localparam logic [2:0] OP_ADD_VERTEX = 3'd0;
  localparam logic [2:0] OP_ADD_EDGE   = 3'd1;
  localparam logic [2:0] OP_REM_VERTEX = 3'd2;
  localparam logic [2:0] OP_REM_EDGE   = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;
  localparam logic [2:0] OP_MIN_VERTEX = 3'd5;

  localparam logic [2:0] KIND_EXISTS = 3'd0;
  localparam logic [2:0] KIND_ABSENT = 3'd1;
  localparam logic [2:0] KIND_ADJ    = 3'd2;
  localparam logic [2:0] KIND_MIN    = 3'd3;
  localparam logic [2:0] KIND_EMPTY  = 3'd4;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       result_kind;
    logic             adjacent;
    logic [VTX_W-1:0] vertex_out;
    logic [VTX_W-1:0] degree_out;
  } result_t;

  typedef struct packed {
    logic          rd_en;
    logic [VW-1:0] rd_addr;
    logic          wr_en;
    logic [VW-1:0] wr_addr;
    logic [NV-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cnt_ctl_t;

  function automatic logic [NV-1:0] bit_mask(logic [VW-1:0] idx);
    return {{(NV-1){1'b0}}, 1'b1} << idx;
  endfunction

endpackage

// ===== design/amgs_row_ram.sv =====
// ----------------------------------------------------------------------------
// amgs_row_ram
// Adjacency row memory, one read and one write port, registered read data.
// A row never written since reset reads as all zeros.
// ----------------------------------------------------------------------------
module amgs_row_ram
  import amgs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  ram_req_t      req,
  output logic [NV-1:0] rd_data
);

  logic [NV-1:0] mem [NV];
  logic [NV-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= row_valid[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (req.wr_en) begin
      row_valid[req.wr_addr] <= 1'b1;
    end
  end

endmodule

// ===== design/amgs_bit_counter.sv =====
// ----------------------------------------------------------------------------
// amgs_bit_counter
// Serial population count: a row is shifted out one bit per cycle while shift is high.
// ----------------------------------------------------------------------------
module amgs_bit_counter
  import amgs_pkg::*;
(
  input  logic          clk,
  input  cnt_ctl_t      ctl,
  input  logic [NV-1:0] data,
  output logic [CW-1:0] count
);

  logic [NV-1:0] sh;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sh    <= data;
      count <= '0;
    end else if (ctl.shift) begin
      sh    <= sh >> 1;
      count <= count + CW'(sh[0]);
    end
  end

endmodule

// ===== design/adjacency_matrix_graph_store.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Undirected graph store: vertex presence bits and a symmetric adjacency
// matrix held one row per memory word.
//
// A command item is taken when start is high and busy is low. At most one
// result item follows, shown for one cycle with done high; the receiver
// cannot stall it. How each command is worked:
//   add vertex          presence bit only, no row access
//   add / remove edge   read-modify-write of both rows,
//                       no row access when a vertex number is out of range
//   remove vertex       sweep of all rows clearing the column
//   adjacency query     two rows counted bit-serially in parallel
//   min vertex          scan for the first present vertex, then its row
//                       is counted bit-serially; an empty graph ends the scan
// The presence scan and the degree count run one bit per cycle. One item
// is worked on at a time.
// Reset empties the graph at once (row valid bits), no clearing pass.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store
  import amgs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_E_RDA,
    S_E_CHKA,
    S_E_RDB,
    S_E_WRB,
    S_SWEEP,
    S_Q_RDA,
    S_Q_RDB,
    S_Q_LDB,
    S_M_SCAN,
    S_M_LD,
    S_CNT,
    S_OUT
  } state_t;

  state_t           state;
  logic [2:0]       op;
  logic [VTX_W-1:0] va;
  logic [VTX_W-1:0] vb;
  logic             ok_a;
  logic             ok_b;
  logic             adj;
  logic [CW-1:0]    cnt;
  logic [VW-1:0]    min_idx;
  logic [NV-1:0]    present;
  logic [NV-1:0]    scan_sh;

  ram_req_t         ram_req;
  logic [NV-1:0]    rd_data;
  cnt_ctl_t         ctl_a;
  cnt_ctl_t         ctl_b;
  logic [NV-1:0]    data_a;
  logic [NV-1:0]    data_b;
  logic [CW-1:0]    deg_a;
  logic [CW-1:0]    deg_b;

  logic             in_ok_a;
  logic             in_ok_b;
  logic [VW-1:0]    in_a_idx;
  logic [VW-1:0]    a_idx;
  logic [VW-1:0]    b_idx;
  logic             is_add;
  logic             hit;
  logic [VW-1:0]    sweep_row;

  assign busy      = (state != S_IDLE);
  assign in_ok_a   = (cmd.vertex_a != '0) && (cmd.vertex_a <= VTX_W'(NV));
  assign in_ok_b   = (cmd.vertex_b != '0) && (cmd.vertex_b <= VTX_W'(NV));
  assign in_a_idx  = VW'(cmd.vertex_a - VTX_W'(1));
  assign a_idx     = VW'(va - VTX_W'(1));
  assign b_idx     = VW'(vb - VTX_W'(1));
  assign is_add    = (op == OP_ADD_EDGE);
  assign hit       = rd_data[b_idx];
  assign sweep_row = VW'(cnt - CW'(1));

  amgs_row_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  amgs_bit_counter u_cnt_a (
    .clk   (clk),
    .ctl   (ctl_a),
    .data  (data_a),
    .count (deg_a)
  );

  amgs_bit_counter u_cnt_b (
    .clk   (clk),
    .ctl   (ctl_b),
    .data  (data_b),
    .count (deg_b)
  );

  always_comb begin
    ram_req = '0;
    ctl_a   = '0;
    ctl_b   = '0;
    data_a  = rd_data;
    data_b  = rd_data;
    case (state)
      S_E_RDA: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = a_idx;
      end
      S_E_CHKA: begin
        ram_req.wr_en   = is_add ? !hit : hit;
        ram_req.wr_addr = a_idx;
        ram_req.wr_data = is_add ? (rd_data | bit_mask(b_idx))
                                 : (rd_data & ~bit_mask(b_idx));
      end
      S_E_RDB: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = b_idx;
      end
      S_E_WRB: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = b_idx;
        ram_req.wr_data = is_add ? (rd_data | bit_mask(a_idx))
                                 : (rd_data & ~bit_mask(a_idx));
      end
      S_SWEEP: begin
        // read row cnt while writing back row cnt-1
        ram_req.rd_en   = (cnt < CW'(NV));
        ram_req.rd_addr = VW'(cnt);
        ram_req.wr_en   = (cnt != '0);
        ram_req.wr_addr = sweep_row;
        ram_req.wr_data = (sweep_row == a_idx) ? '0 : (rd_data & ~bit_mask(a_idx));
      end
      S_Q_RDA: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = a_idx;
      end
      S_Q_RDB: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = b_idx;
        ctl_a.load      = 1'b1;
        data_a          = ok_a ? rd_data : '0;
      end
      S_Q_LDB: begin
        ctl_b.load = 1'b1;
        data_b     = ok_b ? rd_data : '0;
      end
      S_M_SCAN: begin
        ram_req.rd_en   = scan_sh[0];
        ram_req.rd_addr = VW'(cnt);
      end
      S_M_LD: begin
        ctl_a.load = 1'b1;
        ctl_b.load = 1'b1;
      end
      S_CNT: begin
        ctl_a.shift = 1'b1;
        ctl_b.shift = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      present <= '0;
    end else begin
      done   <= 1'b0;
      result <= '0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op   <= cmd.opcode;
            va   <= cmd.vertex_a;
            vb   <= cmd.vertex_b;
            ok_a <= in_ok_a;
            ok_b <= in_ok_b;
            cnt  <= '0;
            case (cmd.opcode)
              OP_ADD_VERTEX: begin
                if (in_ok_a) begin
                  if (present[in_a_idx]) begin
                    done               <= 1'b1;
                    result.result_kind <= KIND_EXISTS;
                  end else begin
                    present[in_a_idx] <= 1'b1;
                  end
                end
              end
              OP_ADD_EDGE, OP_REM_EDGE: begin
                if (in_ok_a && in_ok_b) begin
                  state <= S_E_RDA;
                end
              end
              OP_REM_VERTEX: begin
                if (in_ok_a) begin
                  present[in_a_idx] <= 1'b0;
                  state             <= S_SWEEP;
                end
              end
              OP_QUERY: begin
                state <= S_Q_RDA;
              end
              OP_MIN_VERTEX: begin
                scan_sh <= present;
                state   <= S_M_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_E_RDA: begin
          state <= S_E_CHKA;
        end
        S_E_CHKA: begin
          if (is_add ? hit : !hit) begin
            done               <= 1'b1;
            result.result_kind <= is_add ? KIND_EXISTS : KIND_ABSENT;
            state              <= S_IDLE;
          end else begin
            state <= S_E_RDB;
          end
        end
        S_E_RDB: begin
          state <= S_E_WRB;
        end
        S_E_WRB: begin
          state <= S_IDLE;
        end
        S_SWEEP: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(NV)) begin
            state <= S_IDLE;
          end
        end
        S_Q_RDA: begin
          state <= S_Q_RDB;
        end
        S_Q_RDB: begin
          adj   <= ok_a && ok_b && hit;
          state <= S_Q_LDB;
        end
        S_Q_LDB: begin
          state <= S_CNT;
        end
        S_M_SCAN: begin
          if (scan_sh[0]) begin
            min_idx <= VW'(cnt);
            state   <= S_M_LD;
          end else if (cnt == CW'(NV - 1)) begin
            done               <= 1'b1;
            result.result_kind <= KIND_EMPTY;
            state              <= S_IDLE;
          end else begin
            scan_sh <= scan_sh >> 1;
            cnt     <= cnt + CW'(1);
          end
        end
        S_M_LD: begin
          cnt   <= '0;
          state <= S_CNT;
        end
        S_CNT: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(NV - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (op == OP_MIN_VERTEX) begin
            result.result_kind <= KIND_MIN;
            result.vertex_out  <= VTX_W'(min_idx) + VTX_W'(1);
            result.degree_out  <= VTX_W'(deg_a);
          end else begin
            result.result_kind <= KIND_ADJ;
            result.adjacent    <= adj;
            // lower degree wins, ties to the smaller vertex number
            if (deg_a > deg_b) begin
              result.vertex_out <= vb;
            end else if (deg_a < deg_b) begin
              result.vertex_out <= va;
            end else begin
              result.vertex_out <= (va < vb) ? va : vb;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
